FILE: rtl/brm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the binary bitmap remap block.
// Holds the elaboration-time sine/cosine generator used by the trig table.
package brm_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_OPERATION = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;
  localparam logic [1:0] REG_ANGLE     = 2'd3;

  // Operation codes
  localparam logic [1:0] OP_INVERT    = 2'd0;
  localparam logic [1:0] OP_MIRROR_TB = 2'd1;
  localparam logic [1:0] OP_MIRROR_LR = 2'd2;
  localparam logic [1:0] OP_ROTATE    = 2'd3;

  // Item kinds carried on tuser
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  localparam int CFG_W        = 9;    // widest register
  localparam int COORD_W      = 9;    // image sizes and coordinates in use
  localparam int FIELD_W      = 8;    // row, col and colour fields
  localparam int ANGLE_W      = 9;
  localparam int TRIG_ENTRIES = 360;

  localparam logic [CFG_W-1:0] RESET_SIZE = 9'd256;

  localparam int DEF_MAX_SIDE           = 256;
  localparam int DEF_TRIG_FRACTION_BITS = 14;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADDR,
    ST_DONE
  } brm_state_t;

  // Angle arithmetic in units of 1/(180e9) rad
  localparam longint unsigned UNITS_PER_RAD = 64'd180000000000;
  localparam longint unsigned PI_NUM        = 64'd3141592654;
  localparam longint unsigned PI_UNITS      = PI_NUM * 64'd180;
  localparam longint unsigned TWO_PI_UNITS  = PI_UNITS * 64'd2;
  localparam longint unsigned HALF_PI_UNITS = PI_UNITS / 64'd2;
  localparam longint unsigned ONE_Q30       = 64'd1 << 30;

  // t * x * x in Q30, truncating after each product
  function automatic longint unsigned brm_sq(longint unsigned t, longint unsigned x);
    longint unsigned p;
    p = (t * x) >> 30;
    return (p * x) >> 30;
  endfunction

  // Clamp to [0, 1.0] and round half up to fb fraction bits
  function automatic longint brm_clamp_round(longint v, int fb);
    longint          c;
    longint unsigned u;
    c = v;
    if (c < 0) c = 0;
    if (c > longint'(ONE_Q30)) c = longint'(ONE_Q30);
    u = longint'(c) + (64'd1 << (29 - fb));
    return longint'(u >> (30 - fb));
  endfunction

  // Sine or cosine of (270 - deg*pi/180) rad with fb fraction bits
  function automatic longint brm_trig(int deg, int fb, bit want_sin);
    longint unsigned a;
    longint unsigned q;
    longint unsigned f;
    longint unsigned hi;
    longint unsigned rem;
    longint unsigned xq;
    longint unsigned ts;
    longint unsigned tc;
    longint          as_v;
    longint          ac_v;
    longint          s;
    longint          c;
    longint          sin_v;
    longint          cos_v;
    a   = 64'd270 * UNITS_PER_RAD - longint'(deg) * PI_NUM;
    a   = a % TWO_PI_UNITS;
    q   = a / HALF_PI_UNITS;
    f   = a - q * HALF_PI_UNITS;
    hi  = f << 15;
    rem = hi % UNITS_PER_RAD;
    xq  = ((hi / UNITS_PER_RAD) << 15) + ((rem << 15) / UNITS_PER_RAD);
    ts  = xq;
    tc  = ONE_Q30;
    as_v = longint'(xq);
    ac_v = longint'(ONE_Q30);
    // Taylor terms, alternating sign
    ts = brm_sq(ts, xq) / 6;   tc = brm_sq(tc, xq) / 2;
    as_v = as_v - longint'(ts); ac_v = ac_v - longint'(tc);
    ts = brm_sq(ts, xq) / 20;  tc = brm_sq(tc, xq) / 12;
    as_v = as_v + longint'(ts); ac_v = ac_v + longint'(tc);
    ts = brm_sq(ts, xq) / 42;  tc = brm_sq(tc, xq) / 30;
    as_v = as_v - longint'(ts); ac_v = ac_v - longint'(tc);
    ts = brm_sq(ts, xq) / 72;  tc = brm_sq(tc, xq) / 56;
    as_v = as_v + longint'(ts); ac_v = ac_v + longint'(tc);
    ts = brm_sq(ts, xq) / 110; tc = brm_sq(tc, xq) / 90;
    as_v = as_v - longint'(ts); ac_v = ac_v - longint'(tc);
    ts = brm_sq(ts, xq) / 156; tc = brm_sq(tc, xq) / 132;
    as_v = as_v + longint'(ts); ac_v = ac_v + longint'(tc);
    ts = brm_sq(ts, xq) / 210; tc = brm_sq(tc, xq) / 182;
    as_v = as_v - longint'(ts); ac_v = ac_v - longint'(tc);
    ts = brm_sq(ts, xq) / 272; tc = brm_sq(tc, xq) / 240;
    as_v = as_v + longint'(ts); ac_v = ac_v + longint'(tc);
    ts = brm_sq(ts, xq) / 342; tc = brm_sq(tc, xq) / 306;
    as_v = as_v - longint'(ts); ac_v = ac_v - longint'(tc);
    ts = brm_sq(ts, xq) / 420; tc = brm_sq(tc, xq) / 380;
    as_v = as_v + longint'(ts); ac_v = ac_v + longint'(tc);
    ts = brm_sq(ts, xq) / 506; tc = brm_sq(tc, xq) / 462;
    as_v = as_v - longint'(ts); ac_v = ac_v - longint'(tc);
    ts = brm_sq(ts, xq) / 600; tc = brm_sq(tc, xq) / 552;
    as_v = as_v + longint'(ts); ac_v = ac_v + longint'(tc);
    s = brm_clamp_round(as_v, fb);
    c = brm_clamp_round(ac_v, fb);
    case (q[1:0])
      2'd0:    begin sin_v = s;  cos_v = c;  end
      2'd1:    begin sin_v = c;  cos_v = -s; end
      2'd2:    begin sin_v = -s; cos_v = -c; end
      default: begin sin_v = -c; cos_v = s;  end
    endcase
    return want_sin ? sin_v : cos_v;
  endfunction

endpackage

FILE: rtl/brm_trig_rom.sv
`timescale 1ns / 1ps
// Sine/cosine table of 360 entries with a registered read port.
// Depends on brm_pkg for the table generator and angle constants.
module brm_trig_rom import brm_pkg::*; #(
  parameter int FRAC_BITS = DEF_TRIG_FRACTION_BITS
) (
  input  logic                      clk,
  input  logic [ANGLE_W-1:0]        angle_idx,
  output logic signed [FRAC_BITS+1:0] sin_val,
  output logic signed [FRAC_BITS+1:0] cos_val
);

  localparam int TrigW = FRAC_BITS + 2;

  logic signed [TrigW-1:0] sin_tab [TRIG_ENTRIES];
  logic signed [TrigW-1:0] cos_tab [TRIG_ENTRIES];

  for (genvar d = 0; d < TRIG_ENTRIES; d++) begin : g_entry
    localparam longint SinV = brm_trig(d, FRAC_BITS, 1'b1);
    localparam longint CosV = brm_trig(d, FRAC_BITS, 1'b0);
    assign sin_tab[d] = TrigW'(SinV);
    assign cos_tab[d] = TrigW'(CosV);
  end

  // angle_idx is kept below 360 by the register write logic
  always_ff @(posedge clk) begin
    sin_val <= sin_tab[angle_idx];
    cos_val <= cos_tab[angle_idx];
  end

endmodule

FILE: rtl/binary_bitmap_remap.sv
`timescale 1ns / 1ps
// One-bit bitmap store with inverted, mirrored or rotated read-back. A write word
// (tuser 0) stores one pixel, black when red, green and blue are all zero, and gives
// no result. A read word (tuser 1) gives one result word and goes through the steps
// accept, multiply by sine/cosine, source address and pixel memory read, result;
// the pixel memory read and the multiply are registered, and the result step holds
// while the output register is full and not being taken. The next word is taken while
// a result still waits in the output register. Pixels must be written before they are
// read back; there is no clearing pass. Depends on brm_pkg and brm_trig_rom.
module binary_bitmap_remap import brm_pkg::*; #(
  parameter int MAX_SIDE           = DEF_MAX_SIDE,
  parameter int TRIG_FRACTION_BITS = DEF_TRIG_FRACTION_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [39:0]       s_axis_tdata,  // row, col, red, green, blue
  input  logic              s_axis_tuser,  // mode
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,  // pixel_black, out_of_range, zero fill
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int F        = TRIG_FRACTION_BITS;
  localparam int TrigW    = F + 2;
  localparam int DiffW    = COORD_W + 1;
  localparam int ProdW    = DiffW + TrigW;
  localparam int SumW     = ProdW + 2;
  localparam int IntW     = SumW - F;
  localparam int MemDepth = MAX_SIDE * MAX_SIDE;
  localparam int AddrW    = $clog2(MemDepth);

  // Configuration
  logic [1:0]         operation;
  logic [CFG_W-1:0]   image_width;
  logic [CFG_W-1:0]   image_height;
  logic [ANGLE_W-1:0] angle_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      operation    <= OP_INVERT;
      image_width  <= RESET_SIZE;
      image_height <= RESET_SIZE;
      angle_idx    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OPERATION: operation    <= cfg_data[1:0];
        REG_WIDTH:     image_width  <= cfg_data;
        REG_HEIGHT:    image_height <= cfg_data;
        REG_ANGLE: begin
          // fold 360..511 onto the same angle
          if (cfg_data >= CFG_W'(TRIG_ENTRIES)) begin
            angle_idx <= cfg_data - CFG_W'(TRIG_ENTRIES);
          end else begin
            angle_idx <= cfg_data;
          end
        end
        default: ;
      endcase
    end
  end

  logic [COORD_W-1:0] w_use;
  logic [COORD_W-1:0] h_use;
  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cy;

  assign w_use = (32'(image_width) < MAX_SIDE) ? image_width : COORD_W'(MAX_SIDE);
  assign h_use = (32'(image_height) < MAX_SIDE) ? image_height : COORD_W'(MAX_SIDE);
  assign cx    = w_use >> 1;
  assign cy    = h_use >> 1;

  logic signed [TrigW-1:0] sin_val;
  logic signed [TrigW-1:0] cos_val;

  brm_trig_rom #(
    .FRAC_BITS (F)
  ) u_trig (
    .clk       (clk),
    .angle_idx (angle_idx),
    .sin_val   (sin_val),
    .cos_val   (cos_val)
  );

  // Input word fields
  logic [FIELD_W-1:0] in_row;
  logic [FIELD_W-1:0] in_col;
  logic               in_black;

  assign in_row   = s_axis_tdata[7:0];
  assign in_col   = s_axis_tdata[15:8];
  assign in_black = (s_axis_tdata[39:16] == '0);

  brm_state_t state;
  brm_state_t state_next;
  logic       s_acc;
  logic       wr_en;
  logic       load_out;

  // Pixel memory
  logic             pix_mem [MemDepth];
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;
  logic             rd_bit;

  assign wr_addr = AddrW'(in_row) * AddrW'(MAX_SIDE) + AddrW'(in_col);

  // Request and stage registers
  logic [COORD_W-1:0]      req_row;
  logic [COORD_W-1:0]      req_col;
  logic                    is_oor;
  logic                    use_rot;
  logic                    invert;
  logic [COORD_W-1:0]      plain_row;
  logic [COORD_W-1:0]      plain_col;
  logic signed [ProdW-1:0] p_rc;
  logic signed [ProdW-1:0] p_cs;
  logic signed [ProdW-1:0] p_rs;
  logic signed [ProdW-1:0] p_cc;
  logic                    force_white;

  logic signed [DiffW-1:0] dr;
  logic signed [DiffW-1:0] dc;

  assign dr = $signed({1'b0, req_row}) - $signed({1'b0, cy});
  assign dc = $signed({1'b0, req_col}) - $signed({1'b0, cx});

  // Rotated source coordinate
  logic signed [SumW-1:0] sr;
  logic signed [SumW-1:0] sc;
  logic [IntW-1:0]        sr_int;
  logic [IntW-1:0]        sc_int;
  logic                   rot_outside;
  logic [COORD_W-1:0]     src_row;
  logic [COORD_W-1:0]     src_col;

  always_comb begin
    sr = SumW'(p_rc) - SumW'(p_cs)
       + $signed({{(SumW-COORD_W-F){1'b0}}, cy, {F{1'b0}}});
    sc = SumW'(p_rs) + SumW'(p_cc)
       + $signed({{(SumW-COORD_W-F){1'b0}}, cx, {F{1'b0}}});
    sr_int = sr[SumW-1:F];
    sc_int = sc[SumW-1:F];
    rot_outside = sr[SumW-1] || sc[SumW-1]
               || (sr_int >= IntW'(h_use)) || (sc_int >= IntW'(w_use));
    if (use_rot) begin
      src_row = sr_int[COORD_W-1:0];
      src_col = sc_int[COORD_W-1:0];
    end else begin
      src_row = plain_row;
      src_col = plain_col;
    end
    rd_addr = AddrW'(src_row) * AddrW'(MAX_SIDE) + AddrW'(src_col);
  end

  // Output register
  logic out_valid;
  logic out_black;
  logic out_oor;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_oor, out_black};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    s_acc         = 1'b0;
    wr_en         = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        s_acc         = s_axis_tvalid;
        if (s_axis_tvalid) begin
          if (s_axis_tuser == MODE_READ) begin
            state_next = ST_MUL;
          end else begin
            wr_en = (32'(in_row) < MAX_SIDE) && (32'(in_col) < MAX_SIDE);
          end
        end
      end
      ST_MUL:  state_next = ST_ADDR;
      ST_ADDR: state_next = ST_DONE;
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pix_mem[wr_addr] <= in_black;
    end
    if (state == ST_ADDR) begin
      rd_bit <= pix_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      req_row <= COORD_W'(in_row);
      req_col <= COORD_W'(in_col);
    end
    if (state == ST_MUL) begin
      is_oor    <= (req_row >= h_use) || (req_col >= w_use);
      use_rot   <= (operation == OP_ROTATE) && (h_use == w_use);
      invert    <= (operation == OP_INVERT);
      plain_row <= (operation == OP_MIRROR_TB) ? h_use - 1'b1 - req_row : req_row;
      plain_col <= (operation == OP_MIRROR_LR) ? w_use - 1'b1 - req_col : req_col;
      p_rc      <= dr * cos_val;
      p_cs      <= dc * sin_val;
      p_rs      <= dr * sin_val;
      p_cc      <= dc * cos_val;
    end
    if (state == ST_ADDR) begin
      force_white <= use_rot && rot_outside;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_oor   <= is_oor;
      out_black <= !is_oor && !force_white && (rd_bit ^ invert);
    end
  end

  // The pixel memory is written only between items
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == ST_IDLE)
    else $error("pixel write outside idle");

  // An out-of-range read never reports black
  a_oor_white: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_oor |-> !out_black)
    else $error("out-of-range result marked black");

  // A new result comes only from the last step of a read
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    load_out |-> $past(state) == ST_ADDR || $past(state) == ST_DONE)
    else $error("result loaded without memory read");

  // A read word is followed by the multiply step
  a_read_seq: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_axis_tuser == MODE_READ |=> state == ST_MUL)
    else $error("read word did not start processing");

endmodule

FILE: dv/binary_bitmap_remap_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for binary_bitmap_remap: writes pixels, reads them back through
// every remap setting, and checks each result word against a predictor kept here.
// Depends on brm_pkg and the binary_bitmap_remap RTL.
module binary_bitmap_remap_tb;
  import brm_pkg::*;

  localparam int SIDE         = DEF_MAX_SIDE;
  localparam int FRAC         = DEF_TRIG_FRACTION_BITS;
  localparam int SETTLE_TICKS = 8;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] col;
    logic [7:0] row;
  } pixel_word_t;

  typedef struct packed {
    logic out_of_range;
    logic pixel_black;
  } pixel_result_t;

  typedef struct {
    bit          oor;
    bit          hit;
    bit          flip;
    logic [15:0] addr;
  } pixel_source_t;

  logic             clk;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [39:0]      s_axis_tdata;
  logic             s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [7:0]       m_axis_tdata;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // Predictor state
  bit            black_map [0:SIDE*SIDE-1];
  bit            written   [0:SIDE*SIDE-1];
  int            sin_q14   [0:TRIG_ENTRIES-1];
  int            cos_q14   [0:TRIG_ENTRIES-1];
  logic [1:0]    cur_op     = OP_INVERT;
  logic [8:0]    cur_width  = RESET_SIZE;
  logic [8:0]    cur_height = RESET_SIZE;
  logic [8:0]    cur_angle  = '0;
  pixel_result_t pending_pixels[$];

  int mismatches    = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_left    = 0;

  binary_bitmap_remap dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Clamp to [0, 1.0] in Q30 and round half up to Q14
  function automatic longint round_q14(longint v);
    longint unsigned u;
    if (v < 0) v = 0;
    if (v > longint'(64'd1 << 30)) v = longint'(64'd1 << 30);
    u = longint'(v) + (64'd1 << (29 - FRAC));
    return longint'(u >> (30 - FRAC));
  endfunction

  // Sine/cosine tables for angle 270 - d*pi/180 rad, angle kept in units of 1/(180e9) rad
  initial begin : trig_build
    longint unsigned units_per_rad;
    longint unsigned pi_units;
    longint unsigned half;
    longint unsigned ang;
    longint unsigned quad;
    longint unsigned frac;
    longint unsigned hi;
    longint unsigned rem;
    longint unsigned xq;
    longint unsigned ts;
    longint unsigned tc;
    longint          sum_s;
    longint          sum_c;
    longint          s;
    longint          c;
    units_per_rad = 64'd180000000000;
    pi_units      = 64'd3141592654 * 64'd180;
    half          = pi_units / 64'd2;
    for (longint unsigned d = 0; d < 360; d++) begin
      ang  = 64'd270 * units_per_rad - d * 64'd3141592654;
      ang  = ang % (64'd2 * pi_units);
      quad = ang / half;
      frac = ang - quad * half;
      hi   = frac << 15;
      rem  = hi % units_per_rad;
      xq   = ((hi / units_per_rad) << 15) + ((rem << 15) / units_per_rad);
      ts    = xq;
      tc    = 64'd1 << 30;
      sum_s = longint'(xq);
      sum_c = longint'(64'd1 << 30);
      for (longint unsigned k = 1; k <= 12; k++) begin
        ts = (ts * xq) >> 30;
        ts = (ts * xq) >> 30;
        ts = ts / ((2 * k) * (2 * k + 1));
        tc = (tc * xq) >> 30;
        tc = (tc * xq) >> 30;
        tc = tc / ((2 * k - 1) * (2 * k));
        if (k[0]) begin
          sum_s -= longint'(ts);
          sum_c -= longint'(tc);
        end else begin
          sum_s += longint'(ts);
          sum_c += longint'(tc);
        end
      end
      s = round_q14(sum_s);
      c = round_q14(sum_c);
      case (quad[1:0])
        2'd0:    begin sin_q14[d] = int'(s);  cos_q14[d] = int'(c);  end
        2'd1:    begin sin_q14[d] = int'(c);  cos_q14[d] = int'(-s); end
        2'd2:    begin sin_q14[d] = int'(-s); cos_q14[d] = int'(-c); end
        default: begin sin_q14[d] = int'(-c); cos_q14[d] = int'(s);  end
      endcase
    end
  end

  function automatic int clamp_side(logic [8:0] size);
    return (int'(size) > SIDE) ? SIDE : int'(size);
  endfunction

  // Locate the stored pixel a read at (row, col) lands on under the current setting
  function automatic pixel_source_t trace_source(logic [7:0] row, logic [7:0] col);
    pixel_source_t src;
    int            w;
    int            h;
    longint        sn;
    longint        cs;
    longint        cy;
    longint        cx;
    longint        dr;
    longint        dc;
    longint        sr;
    longint        sc;
    src = '{oor: 1'b0, hit: 1'b0, flip: 1'b0, addr: '0};
    w = clamp_side(cur_width);
    h = clamp_side(cur_height);
    if (int'(row) >= h || int'(col) >= w) begin
      src.oor = 1'b1;
      return src;
    end
    src.hit = 1'b1;
    case (cur_op)
      OP_INVERT: begin
        src.flip = 1'b1;
        src.addr = {row, col};
      end
      OP_MIRROR_TB: src.addr = {8'(h - 1 - int'(row)), col};
      OP_MIRROR_LR: src.addr = {row, 8'(w - 1 - int'(col))};
      default: begin
        if (h != w) begin
          src.addr = {row, col};
        end else begin
          sn = sin_q14[cur_angle % TRIG_ENTRIES];
          cs = cos_q14[cur_angle % TRIG_ENTRIES];
          cy = h / 2;
          cx = w / 2;
          dr = longint'(row) - cy;
          dc = longint'(col) - cx;
          sr = dr * cs - dc * sn + (cy <<< FRAC);
          sc = dr * sn + dc * cs + (cx <<< FRAC);
          // source beyond the image reads white
          if (sr < 0 || sc < 0 || sr >= (longint'(h) <<< FRAC) ||
              sc >= (longint'(w) <<< FRAC)) begin
            src.hit = 1'b0;
          end else begin
            src.addr = {8'(sr >>> FRAC), 8'(sc >>> FRAC)};
          end
        end
      end
    endcase
    return src;
  endfunction

  // Offer one word, hold until taken, then apply it to the predictor
  task automatic send_word(input logic mode, input pixel_word_t word);
    pixel_source_t src;
    pixel_result_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (mode == MODE_WRITE) begin
      black_map[{word.row, word.col}] = ({word.red, word.green, word.blue} == '0);
      written[{word.row, word.col}]   = 1'b1;
    end else begin
      src = trace_source(word.row, word.col);
      want.out_of_range = src.oor;
      want.pixel_black  = src.hit ? (black_map[src.addr] ^ src.flip) : 1'b0;
      pending_pixels.push_back(want);
    end
    @(negedge clk);
  endtask

  function automatic pixel_word_t colour_word(logic [7:0] row, logic [7:0] col);
    pixel_word_t word;
    word.row = row;
    word.col = col;
    if ($urandom_range(0, 1)) begin
      {word.blue, word.green, word.red} = '0;
    end else begin
      word.red   = $urandom_range(0, 1) ? 8'd0 : 8'($urandom);
      word.green = $urandom_range(0, 1) ? 8'd0 : 8'($urandom);
      word.blue  = $urandom_range(0, 1) ? 8'd0 : 8'($urandom);
    end
    return word;
  endfunction

  task automatic write_pixel(input logic [7:0] row, input logic [7:0] col,
                             input logic [23:0] bgr);
    pixel_word_t word;
    word = colour_word(row, col);
    {word.blue, word.green, word.red} = bgr;
    send_word(MODE_WRITE, word);
  endtask

  // Read back one pixel; paint its source first if it was never written
  task automatic read_pixel(input logic [7:0] row, input logic [7:0] col);
    pixel_source_t src;
    pixel_word_t   word;
    src = trace_source(row, col);
    if (!src.oor && src.hit && !written[src.addr])
      send_word(MODE_WRITE, colour_word(src.addr[15:8], src.addr[7:0]));
    word.row = row;
    word.col = col;
    {word.blue, word.green, word.red} = 24'($urandom);
    send_word(MODE_READ, word);
  endtask

  // Hold input, wait for every result, then let the last writes finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic configure(input logic [1:0] op, input logic [8:0] w, input logic [8:0] h,
                           input logic [8:0] angle);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_OPERATION;
    cfg_data  <= 9'(op);
    @(negedge clk);
    cfg_index <= REG_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_index <= REG_ANGLE;
    cfg_data  <= angle;
    @(negedge clk);
    cfg_we     <= 1'b0;
    cur_op     = op;
    cur_width  = w;
    cur_height = h;
    cur_angle  = angle;
  endtask

  function automatic logic [8:0] pick_size();
    case ($urandom_range(0, 19))
      0, 1:    return 9'd1;
      2, 3:    return 9'd256;
      4:       return 9'd0;
      5:       return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(2, 32));
    endcase
  endfunction

  function automatic logic [8:0] pick_angle();
    case ($urandom_range(0, 9))
      0:       return 9'd0;
      1:       return 9'd359;
      2:       return 9'(90 * $urandom_range(1, 3));
      3:       return 9'($urandom_range(360, 511));
      default: return 9'($urandom_range(0, 359));
    endcase
  endfunction

  // Mostly inside the size in use, otherwise anywhere
  function automatic logic [7:0] pick_coord(logic [8:0] size, int inside_pct);
    int lim;
    lim = clamp_side(size);
    if (lim > 0 && $urandom_range(0, 99) < inside_pct) return 8'($urandom_range(0, lim - 1));
    return 8'($urandom);
  endfunction

  task automatic random_traffic(input int count);
    repeat (count) begin
      if ($urandom_range(0, 99) < 35)
        send_word(MODE_WRITE, colour_word(pick_coord(cur_height, 70),
                                          pick_coord(cur_width, 70)));
      else
        read_pixel(pick_coord(cur_height, 85), pick_coord(cur_width, 85));
    end
  endtask

  task automatic test_special_cases();
    write_pixel(8'd0, 8'd0, 24'h000000);
    write_pixel(8'd255, 8'd255, 24'hFFFFFF);
    write_pixel(8'd0, 8'd255, 24'h010000);
    write_pixel(8'd255, 8'd0, 24'h000000);
    // reset setting: invert over the full store
    read_pixel(8'd0, 8'd0);
    read_pixel(8'd255, 8'd255);
    configure(OP_MIRROR_TB, 9'd256, 9'd256, 9'd0);
    read_pixel(8'd0, 8'd0);
    configure(OP_MIRROR_LR, 9'd256, 9'd256, 9'd0);
    read_pixel(8'd0, 8'd0);
    configure(OP_ROTATE, 9'd256, 9'd256, 9'd90);
    read_pixel(8'd0, 8'd0);
    read_pixel(8'd128, 8'd128);
    read_pixel(8'd255, 8'd255);
    // non-square rotate passes the stored pixel through
    configure(OP_ROTATE, 9'd16, 9'd8, 9'd45);
    read_pixel(8'd3, 8'd3);
    // width past the store clamps, angle past 359 wraps
    configure(OP_ROTATE, 9'd300, 9'd256, 9'd400);
    read_pixel(8'd10, 8'd20);
    configure(OP_INVERT, 9'd8, 9'd0, 9'd0);
    read_pixel(8'd0, 8'd0);
    configure(OP_INVERT, 9'd8, 9'd8, 9'd359);
    read_pixel(8'd7, 8'd8);
    read_pixel(8'd8, 8'd7);
    read_pixel(8'd7, 8'd7);
  endtask

  task automatic test_random_remap();
    logic [8:0] w;
    logic [8:0] h;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (int op = 0; op < 4; op++) begin
        w = pick_size();
        h = (op == OP_ROTATE && $urandom_range(0, 3) != 0) ? w : pick_size();
        configure(2'(op), w, h, pick_angle());
        random_traffic(90);
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(OP_MIRROR_LR, 9'd16, 9'd16, 9'd0);
    // receiver holds off while reads keep coming, so the input must stall
    stall_left = 300;
    repeat (40) read_pixel(8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)));
    settle();
    recv_stall_pct = 30;
    random_traffic(40);
    settle();
    random_traffic(30);
  endtask

  initial begin : result_check
    pixel_result_t got;
    pixel_result_t want;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[1:0];
        if (pending_pixels.size() == 0) begin
          mismatches++;
          $error("unexpected result word %h", m_axis_tdata);
        end else begin
          want = pending_pixels.pop_front();
          if (got.pixel_black !== want.pixel_black) begin
            mismatches++;
            $error("pixel_black: expected %0d, got %0d", want.pixel_black, got.pixel_black);
          end
          if (got.out_of_range !== want.out_of_range) begin
            mismatches++;
            $error("out_of_range: expected %0d, got %0d", want.out_of_range,
                   got.out_of_range);
          end
        end
      end
      @(negedge clk);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin : stimulus
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_WRITE;
    cfg_we        = 1'b0;
    cfg_index     = REG_OPERATION;
    cfg_data      = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_special_cases();
    test_random_remap();
    test_backpressure();
    settle();
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
